FILE: src/swrc_pkg.sv
// ----------------------------------------------------------------------------
// swrc_pkg
// types, codes and the crc-32 byte step for the stop-and-wait receiver
// ----------------------------------------------------------------------------
package swrc_pkg;

    // sequence counter width, 8 to 32
    localparam int SEQ_BITS = 32;

    localparam int OP_W      = 2;
    localparam int TYPE_W    = 3;
    localparam int VERDICT_W = 3;
    localparam int CRC_W     = 32;
    localparam int SEQ_PORT_W = 32;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 72;

    typedef logic [SEQ_BITS-1:0]  seq_t;
    typedef logic [CRC_W-1:0]     crc_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [TYPE_W-1:0]    ptype_t;
    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam crc_t CRC_INIT = 32'hFFFF_FFFF;
    localparam crc_t CRC_POLY = 32'hEDB8_8320;

    // item operations
    localparam op_t OP_BYTE    = 2'd0;
    localparam op_t OP_TRAILER = 2'd1;
    localparam op_t OP_START   = 2'd2;

    // trailer packet types
    localparam ptype_t TYPE_DATA  = 3'd3;
    localparam ptype_t TYPE_END   = 3'd5;
    localparam ptype_t TYPE_ERROR = 3'd6;

    // verdict codes
    localparam verdict_t V_ACCEPTED   = 3'd0;
    localparam verdict_t V_OOO_ACK    = 3'd1;
    localparam verdict_t V_OOO_SILENT = 3'd2;
    localparam verdict_t V_BAD_CRC    = 3'd3;
    localparam verdict_t V_END        = 3'd4;
    localparam verdict_t V_ERROR      = 3'd5;
    localparam verdict_t V_IGNORED    = 3'd6;

    // reflected crc-32, one byte, lsb first
    function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] data);
        crc_t c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: src/stop_and_wait_receiver_crc32_check.sv
// ----------------------------------------------------------------------------
// stop_and_wait_receiver_crc32_check
// receiver side of a stop-and-wait transfer with a crc-32 packet check
// ----------------------------------------------------------------------------
//
//  channel   dir   tuser (low bit up)   tdata (low bit up)
//  s_axis    in    operation[1:0]       data_byte[7:0], packet_type[10:8],
//                                       sequence_req[42:11], sent_crc[74:43],
//                                       zero pad[79:75]
//  m_axis    out   verdict[2:0]         ack_flag[0], ack_sequence[32:1],
//                                       commit_payload[33], session_over[34],
//                                       computed_crc[66:35], zero pad[71:67]
//
//  one item per cycle sustained while no trailer waits on the result slot; an
//  accepted item lands in the input register and, when it advances, is folded
//  into the session state, and a trailer's verdict is loaded into the result
//  register on that same edge, from where m_axis shows it
//  the bytewise crc step and the verdict compare sit between the input and
//  result registers; while m_axis stalls, byte, start and unused items keep
//  flowing, and a trailer waits in the input register, holding s_axis off,
//  until the result slot frees
//  rst_n clears the valid flags, the crc accumulator to all ones, the expected
//  sequence to zero and the closed flag
//
module stop_and_wait_receiver_crc32_check
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // data_byte, packet_type, sequence_req, sent_crc, zero pad
    input  logic [swrc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic [swrc_pkg::OP_W-1:0]             s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // ack_flag, ack_sequence, commit_payload, session_over, computed_crc, pad
    output logic [swrc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // verdict
    output logic [swrc_pkg::VERDICT_W-1:0]        m_axis_tuser
);

    // input register
    logic                    in_valid_reg, in_valid_next;
    swrc_pkg::op_t           in_op_reg;
    logic [7:0]              in_byte_reg;
    swrc_pkg::ptype_t        in_type_reg;
    logic [swrc_pkg::SEQ_PORT_W-1:0] in_seq_reg;
    swrc_pkg::crc_t          in_sent_reg;

    // session state
    swrc_pkg::crc_t          crc_reg, crc_next;
    swrc_pkg::seq_t          expected_reg, expected_next;
    logic                    closed_reg, closed_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    swrc_pkg::verdict_t      verdict_reg, verdict_next;
    logic                    ack_reg, ack_next;
    logic [swrc_pkg::SEQ_PORT_W-1:0] ack_seq_reg, ack_seq_next;
    logic                    commit_reg, commit_next;
    logic                    over_reg, over_next;
    swrc_pkg::crc_t          final_crc_reg, final_crc_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    is_trailer;
    logic                    advance;
    swrc_pkg::seq_t          seq;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign is_trailer = (in_op_reg == swrc_pkg::OP_TRAILER);
    // a trailer leaves only when the result slot is free
    assign advance    = in_valid_reg && (!is_trailer || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign seq        = in_seq_reg[swrc_pkg::SEQ_BITS-1:0];

    assign in_valid_next = in_accept || (in_valid_reg && !advance);

    always_comb
    begin
        crc_next       = crc_reg;
        expected_next  = expected_reg;
        closed_next    = closed_reg;
        verdict_next   = swrc_pkg::V_IGNORED;
        ack_next       = 1'b0;
        ack_seq_next   = '0;
        commit_next    = 1'b0;
        final_crc_next = ~crc_reg;

        if (advance)
        begin
            case (in_op_reg)
                swrc_pkg::OP_BYTE:
                begin
                    crc_next = swrc_pkg::crc_byte(crc_reg, in_byte_reg);
                end
                swrc_pkg::OP_START:
                begin
                    crc_next      = swrc_pkg::CRC_INIT;
                    expected_next = '0;
                    closed_next   = 1'b0;
                end
                swrc_pkg::OP_TRAILER:
                begin
                    crc_next = swrc_pkg::CRC_INIT;
                    if (closed_reg)
                    begin
                        verdict_next = swrc_pkg::V_IGNORED;
                    end
                    else if (in_type_reg == swrc_pkg::TYPE_ERROR)
                    begin
                        verdict_next = swrc_pkg::V_ERROR;
                        closed_next  = 1'b1;
                    end
                    else if (in_type_reg == swrc_pkg::TYPE_END)
                    begin
                        // end is acked without a crc check
                        verdict_next = swrc_pkg::V_END;
                        ack_next     = 1'b1;
                        ack_seq_next = swrc_pkg::SEQ_PORT_W'(seq);
                        closed_next  = 1'b1;
                    end
                    else if (in_type_reg == swrc_pkg::TYPE_DATA)
                    begin
                        if (in_sent_reg != ~crc_reg)
                        begin
                            verdict_next = swrc_pkg::V_BAD_CRC;
                        end
                        else if (seq == expected_reg)
                        begin
                            verdict_next  = swrc_pkg::V_ACCEPTED;
                            ack_next      = 1'b1;
                            ack_seq_next  = swrc_pkg::SEQ_PORT_W'(seq);
                            commit_next   = 1'b1;
                            expected_next = expected_reg + 1'b1;
                        end
                        else if (expected_reg != '0)
                        begin
                            // re-ack the last packet taken in order
                            verdict_next = swrc_pkg::V_OOO_ACK;
                            ack_next     = 1'b1;
                            ack_seq_next = swrc_pkg::SEQ_PORT_W'(expected_reg - 1'b1);
                        end
                        else
                        begin
                            verdict_next = swrc_pkg::V_OOO_SILENT;
                        end
                    end
                end
                default:
                begin
                    // unused operation, no effect
                end
            endcase
        end
    end

    assign over_next      = closed_next;
    assign out_valid_next = (out_valid_reg && !m_axis_tready) || (advance && is_trailer);

    // control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= swrc_pkg::CRC_INIT;
            expected_reg  <= '0;
            closed_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            expected_reg  <= expected_next;
            closed_reg    <= closed_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata[7:0];
            in_type_reg <= s_axis_tdata[10:8];
            in_seq_reg  <= s_axis_tdata[42:11];
            in_sent_reg <= s_axis_tdata[74:43];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && is_trailer)
        begin
            verdict_reg   <= verdict_next;
            ack_reg       <= ack_next;
            ack_seq_reg   <= ack_seq_next;
            commit_reg    <= commit_next;
            over_reg      <= over_next;
            final_crc_reg <= final_crc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = verdict_reg;
    assign m_axis_tdata  = {5'd0, final_crc_reg, over_reg, commit_reg, ack_seq_reg, ack_reg};

endmodule

FILE: src/swrc_checker.sv
// ----------------------------------------------------------------------------
// swrc_checker
// port-level checks for the stop-and-wait receiver
// ----------------------------------------------------------------------------
module swrc_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [swrc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic [swrc_pkg::OP_W-1:0]             s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [swrc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic [swrc_pkg::VERDICT_W-1:0]        m_axis_tuser
);

    // a waiting input item stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input item changed while waiting");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a result without an ack carries a zero ack sequence
    a_ack_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '0)
        else $error("ack sequence set without ack");

    // commit only with an accepted, acked packet in an open session
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |->
            m_axis_tuser == swrc_pkg::V_ACCEPTED && m_axis_tdata[0] && !m_axis_tdata[34])
        else $error("commit without accepted verdict");

    // end and error verdicts report a closed session
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == swrc_pkg::V_END ||
                          m_axis_tuser == swrc_pkg::V_ERROR) |-> m_axis_tdata[34])
        else $error("session not closed after end or error");

endmodule

bind stop_and_wait_receiver_crc32_check swrc_checker u_swrc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
